// ===== hw/rtl/sfrc_pkg.sv =====
package sfrc_pkg;

	localparam int MAX_FRAME    = 32;
	localparam int BYTE_W       = 8;
	localparam int POS_W        = 5;
	localparam int CNT_W        = 9;
	localparam int HEADER_BYTES = 5;

	localparam logic [BYTE_W-1:0] SUM_BASE    = 8'hFC;
	localparam logic [BYTE_W-1:0] LINK_TYPE   = 8'h7A;
	localparam logic [BYTE_W-1:0] START_RESET = 8'hFC;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_HEAD = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_out;
		logic [POS_W-1:0]  position;
		logic              in_frame;
		logic              frame_end;
		logic              frame_good;
		logic              frame_bad;
		logic              connected;
	} res_t;

endpackage

// ===== hw/rtl/sfrc_in_stage.sv =====
module sfrc_in_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [sfrc_pkg::BYTE_W-1:0] rx_byte,
	input  logic                        adv,
	output logic                        in_stall,
	output logic                        take,
	output logic [sfrc_pkg::BYTE_W-1:0] byte_s1
);

	logic valid_s1;
	logic load;

	assign take     = valid_s1 & adv;
	assign in_stall = valid_s1 & ~adv;
	assign load     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= load | (valid_s1 & ~take);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

// ===== hw/rtl/sfrc_parser.sv =====
module sfrc_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [sfrc_pkg::BYTE_W-1:0] rx_byte,
	input  logic [sfrc_pkg::BYTE_W-1:0] start_byte,
	output sfrc_pkg::res_t              res
);

	sfrc_pkg::phase_t              phase_q, phase_d;
	logic [sfrc_pkg::CNT_W-1:0]    count_q, count_d;
	logic [sfrc_pkg::CNT_W-1:0]    len_q, len_d;
	logic [sfrc_pkg::BYTE_W-1:0]   sum_q, sum_d;
	logic [sfrc_pkg::BYTE_W-1:0]   type_q, type_d;
	logic                          link_q, link_d;

	logic [sfrc_pkg::CNT_W-1:0]    hdr_len;
	logic                          too_long;
	logic                          last_hdr;
	logic                          at_csum;
	logic                          csum_ok;

	assign hdr_len  = {1'b0, rx_byte} + sfrc_pkg::CNT_W'(sfrc_pkg::HEADER_BYTES);
	assign too_long = ({1'b0, hdr_len} + 10'd1) > 10'(sfrc_pkg::MAX_FRAME);
	assign last_hdr = count_q == sfrc_pkg::CNT_W'(sfrc_pkg::HEADER_BYTES - 1);
	assign at_csum  = count_q >= len_q;
	assign csum_ok  = rx_byte == (sfrc_pkg::SUM_BASE - sum_q);

	// next state
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		len_d   = len_q;
		sum_d   = sum_q;
		type_d  = type_q;
		link_d  = link_q;
		case (phase_q)
			sfrc_pkg::PH_HEAD: begin
				sum_d = sum_q + rx_byte;
				if (count_q == sfrc_pkg::CNT_W'(1)) begin
					type_d = rx_byte;
				end
				if (last_hdr) begin
					len_d = hdr_len;
					if (too_long) begin
						phase_d = sfrc_pkg::PH_HUNT;
						count_d = '0;
					end else begin
						phase_d = sfrc_pkg::PH_BODY;
						count_d = sfrc_pkg::CNT_W'(sfrc_pkg::HEADER_BYTES);
					end
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			sfrc_pkg::PH_BODY: begin
				if (at_csum) begin
					if (csum_ok && type_q == sfrc_pkg::LINK_TYPE) begin
						link_d = 1'b1;
					end
					phase_d = sfrc_pkg::PH_HUNT;
					count_d = '0;
				end else begin
					sum_d   = sum_q + rx_byte;
					count_d = count_q + 1'b1;
				end
			end
			default: begin
				phase_d = sfrc_pkg::PH_HUNT;
				if (rx_byte == start_byte) begin
					phase_d = sfrc_pkg::PH_HEAD;
					count_d = sfrc_pkg::CNT_W'(1);
					sum_d   = rx_byte;
					type_d  = '0;
					len_d   = '0;
				end
			end
		endcase
	end

	// outputs
	always_comb begin
		res            = '0;
		res.byte_out   = rx_byte;
		res.connected  = link_d;
		case (phase_q)
			sfrc_pkg::PH_HEAD: begin
				res.position = count_q[sfrc_pkg::POS_W-1:0];
				res.in_frame = 1'b1;
				if (last_hdr && too_long) begin
					res.frame_end = 1'b1;
					res.frame_bad = 1'b1;
				end
			end
			sfrc_pkg::PH_BODY: begin
				res.position = count_q[sfrc_pkg::POS_W-1:0];
				res.in_frame = 1'b1;
				if (at_csum) begin
					res.frame_end  = 1'b1;
					res.frame_good = csum_ok;
					res.frame_bad  = ~csum_ok;
				end
			end
			default: begin
				res.in_frame = rx_byte == start_byte;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sfrc_pkg::PH_HUNT;
			count_q <= '0;
			len_q   <= '0;
			sum_q   <= '0;
			type_q  <= '0;
			link_q  <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			count_q <= count_d;
			len_q   <= len_d;
			sum_q   <= sum_d;
			type_q  <= type_d;
			link_q  <= link_d;
		end
	end

endmodule

// ===== hw/rtl/sfrc_out_stage.sv =====
module sfrc_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  sfrc_pkg::res_t res,
	input  logic           out_stall,
	output logic           adv,
	output logic           out_valid,
	output sfrc_pkg::res_t res_s2
);

	logic valid_s2;

	assign adv       = ~valid_s2 | ~out_stall;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s2 <= res;
		end
	end

endmodule

// ===== hw/rtl/serial_frame_receiver_checksum.sv =====
// Path: an accepted request enters the input register, then the frame state
// update and the result register, which drives the result handshake.
// Throughput: 1 request per cycle unless out_stall holds the pipeline;
// the frame state updates once per byte.
// Reset: arst_n asynchronous, active low; clears the pipeline valids, returns
// the parser to hunting, clears the sticky link flag, start_byte goes to 0xFC.
module serial_frame_receiver_checksum (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [sfrc_pkg::BYTE_W-1:0]         cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [sfrc_pkg::BYTE_W-1:0]         rx_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sfrc_pkg::BYTE_W-1:0]         byte_out,
	output logic [sfrc_pkg::POS_W-1:0]          position,
	output logic                                in_frame,
	output logic                                frame_end,
	output logic                                frame_good,
	output logic                                frame_bad,
	output logic                                connected
);

	logic [sfrc_pkg::BYTE_W-1:0] start_byte_q;
	logic [sfrc_pkg::BYTE_W-1:0] byte_s1;
	logic                        adv;
	logic                        take;
	sfrc_pkg::res_t              res;
	sfrc_pkg::res_t              res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= sfrc_pkg::START_RESET;
		end else if (cfg_wr_en) begin
			start_byte_q <= cfg_wr_data;
		end
	end

	sfrc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.rx_byte  (rx_byte),
		.adv      (adv),
		.in_stall (in_stall),
		.take     (take),
		.byte_s1  (byte_s1)
	);

	sfrc_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.rx_byte    (byte_s1),
		.start_byte (start_byte_q),
		.res        (res)
	);

	sfrc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.res       (res),
		.out_stall (out_stall),
		.adv       (adv),
		.out_valid (out_valid),
		.res_s2    (res_s2)
	);

	assign byte_out   = res_s2.byte_out;
	assign position   = res_s2.position;
	assign in_frame   = res_s2.in_frame;
	assign frame_end  = res_s2.frame_end;
	assign frame_good = res_s2.frame_good;
	assign frame_bad  = res_s2.frame_bad;
	assign connected  = res_s2.connected;

`ifndef SYNTHESIS
	a_good_bad_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(frame_good && frame_bad))
		else $error("frame_good and frame_bad both set");

	a_verdict_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (frame_good || frame_bad)) |-> frame_end)
		else $error("verdict without frame_end");

	a_end_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> in_frame)
		else $error("frame_end outside a frame");

	a_hunt_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !in_frame) |-> (position == '0))
		else $error("nonzero position while hunting");
`endif

endmodule

// ===== sim/tb_serial_frame_receiver_checksum.sv =====
`timescale 1ns / 1ps

module tb_serial_frame_receiver_checksum;
	import sfrc_pkg::*;

	localparam int QUIET_LIMIT = 4000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [BYTE_W-1:0] cfg_wr_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [BYTE_W-1:0] byte_out;
	logic [POS_W-1:0]  position;
	logic             in_frame;
	logic             frame_end;
	logic             frame_good;
	logic             frame_bad;
	logic             connected;

	serial_frame_receiver_checksum u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.byte_out    (byte_out),
		.position    (position),
		.in_frame    (in_frame),
		.frame_end   (frame_end),
		.frame_good  (frame_good),
		.frame_bad   (frame_bad),
		.connected   (connected)
	);

	always #1 clk = ~clk;

	// parser shadow state
	logic [BYTE_W-1:0] start_byte_cfg = START_RESET;
	phase_t            parse_phase = PH_HUNT;
	logic [CNT_W-1:0]  parse_count = '0;
	logic [CNT_W-1:0]  parse_len = '0;
	logic [BYTE_W-1:0] parse_sum = '0;
	logic [BYTE_W-1:0] parse_type = '0;
	logic              link_up = 1'b0;

	logic [BYTE_W-1:0] tx_bytes_q[$];
	res_t              echo_expect_q[$];

	int mismatch_count = 0;
	int results_seen = 0;
	int frames_good = 0;
	int frames_bad = 0;
	int frame_bytes_queued = 0;
	int quiet_cycles = 0;
	int burst_left = 1;
	int gap_left = 0;
	logic [15:0] stall_bits = '0;
	logic        stall_on = 1'b0;
	int          stall_age = 0;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("result %0d %s: got 0x%0h want 0x%0h", results_seen, what, got, want);
		mismatch_count++;
	endtask

	task automatic predict_rx_byte(input logic [BYTE_W-1:0] b);
		res_t r;
		r = '0;
		r.byte_out = b;
		case (parse_phase)
			PH_HEAD: begin
				r.position = parse_count[POS_W-1:0];
				r.in_frame = 1'b1;
				parse_sum = parse_sum + b;
				if (parse_count == 1)
					parse_type = b;
				if (parse_count == HEADER_BYTES - 1) begin
					parse_len = CNT_W'(b) + CNT_W'(HEADER_BYTES);
					if (int'(parse_len) + 1 > MAX_FRAME) begin
						r.frame_end = 1'b1;
						r.frame_bad = 1'b1;
						parse_phase = PH_HUNT;
						parse_count = '0;
					end else begin
						parse_count = CNT_W'(HEADER_BYTES);
						parse_phase = PH_BODY;
					end
				end else begin
					parse_count = parse_count + 1'b1;
				end
			end
			PH_BODY: begin
				r.position = parse_count[POS_W-1:0];
				r.in_frame = 1'b1;
				if (parse_count >= parse_len) begin
					r.frame_end = 1'b1;
					if (b == BYTE_W'(SUM_BASE - parse_sum)) begin
						r.frame_good = 1'b1;
						if (parse_type == LINK_TYPE)
							link_up = 1'b1;
					end else begin
						r.frame_bad = 1'b1;
					end
					parse_phase = PH_HUNT;
					parse_count = '0;
				end else begin
					parse_sum = parse_sum + b;
					parse_count = parse_count + 1'b1;
				end
			end
			default: begin
				parse_phase = PH_HUNT;
				if (b == start_byte_cfg) begin
					r.in_frame = 1'b1;
					parse_phase = PH_HEAD;
					parse_count = 1;
					parse_sum = b;
					parse_type = '0;
					parse_len = '0;
				end
			end
		endcase
		r.connected = link_up;
		echo_expect_q = {echo_expect_q, r};
	endtask

	// keep between 0 and the frame size cuts the frame short; fill_start makes every payload byte the start byte
	task automatic queue_frame(input logic [BYTE_W-1:0] ftype, input logic [BYTE_W-1:0] len,
			input bit corrupt, input int keep, input bit fill_start);
		logic [BYTE_W-1:0] fb[$];
		logic [BYTE_W-1:0] sum;
		fb = {fb, start_byte_cfg};
		fb = {fb, ftype};
		fb = {fb, BYTE_W'($urandom)};
		fb = {fb, BYTE_W'($urandom)};
		fb = {fb, len};
		if (int'(len) + HEADER_BYTES + 1 <= MAX_FRAME) begin
			repeat (len)
				fb = {fb, (fill_start ? start_byte_cfg : BYTE_W'($urandom))};
			sum = '0;
			foreach (fb[i])
				sum = sum + fb[i];
			sum = SUM_BASE - sum;
			if (corrupt)
				sum = sum ^ BYTE_W'($urandom_range(1, 255));
			fb = {fb, sum};
		end
		if (keep > 0 && keep < fb.size())
			fb = fb[0:keep-1];
		foreach (fb[i])
			tx_bytes_q = {tx_bytes_q, fb[i]};
		frame_bytes_queued += fb.size();
	endtask

	task automatic queue_random_traffic(input int n_bytes);
		int goal;
		int kind;
		logic [BYTE_W-1:0] ftype;
		logic [BYTE_W-1:0] len;
		goal = frame_bytes_queued + n_bytes;
		while (frame_bytes_queued < goal) begin
			kind = $urandom_range(0, 9);
			ftype = ($urandom_range(0, 5) == 0) ? LINK_TYPE : BYTE_W'($urandom);
			len = ($urandom_range(0, 5) == 0) ? BYTE_W'(MAX_FRAME - HEADER_BYTES - 1)
				: BYTE_W'($urandom_range(0, 12));
			case (kind)
				6: queue_frame(ftype, len, 1'b1, 0, 1'b0);
				7: queue_frame(ftype, BYTE_W'($urandom_range(MAX_FRAME - HEADER_BYTES, 255)),
					1'b0, 0, 1'b0);
				8: queue_frame(ftype, len, 1'b0, $urandom_range(1, int'(len) + HEADER_BYTES), 1'b0);
				9: repeat ($urandom_range(1, 4))
					tx_bytes_q = {tx_bytes_q, BYTE_W'($urandom)};
				default: queue_frame(ftype, len, 1'b0, 0, 1'b0);
			endcase
		end
	endtask

	task automatic wait_drained;
		do
			@(negedge clk);
		while (tx_bytes_q.size() != 0 || in_valid || echo_expect_q.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_start_byte(input logic [BYTE_W-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		start_byte_cfg = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// request driver: bursts with random gaps, payload held while stalled
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			predict_rx_byte(rx_byte);
		if (!(in_valid && in_stall)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (tx_bytes_q.size() != 0) begin
				in_valid <= 1'b1;
				rx_byte <= tx_bytes_q.pop_front();
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side stall pattern, reloaded whenever stall_age wraps to 0
	always @(posedge clk) begin
		if (stall_age == 0) begin
			stall_bits = 16'($urandom);
			stall_on = ($urandom_range(0, 3) != 0);
		end
		stall_age = (stall_age + 1) % 64;
		stall_bits = {stall_bits[0], stall_bits[15:1]};
		out_stall <= stall_on & stall_bits[0];
	end

	always @(posedge clk) begin : monitor
		res_t want;
		if (out_valid && !out_stall) begin
			if (echo_expect_q.size() == 0) begin
				report_mismatch("unexpected result, byte", byte_out, 0);
			end else begin
				want = echo_expect_q.pop_front();
				if (byte_out !== want.byte_out)
					report_mismatch("byte_out", byte_out, want.byte_out);
				if (position !== want.position)
					report_mismatch("position", position, want.position);
				if (in_frame !== want.in_frame)
					report_mismatch("in_frame", in_frame, want.in_frame);
				if (frame_end !== want.frame_end)
					report_mismatch("frame_end", frame_end, want.frame_end);
				if (frame_good !== want.frame_good)
					report_mismatch("frame_good", frame_good, want.frame_good);
				if (frame_bad !== want.frame_bad)
					report_mismatch("frame_bad", frame_bad, want.frame_bad);
				if (connected !== want.connected)
					report_mismatch("connected", connected, want.connected);
				frames_good += want.frame_good;
				frames_bad += want.frame_bad;
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no request moved for %0d cycles", QUIET_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [BYTE_W-1:0] settings[4];
		settings = '{8'h00, 8'hFF, BYTE_W'($urandom_range(1, 254)), START_RESET};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// noise while hunting, start byte as payload, bad link frame, overlength aborts
		tx_bytes_q = {tx_bytes_q, 8'h00};
		tx_bytes_q = {tx_bytes_q, 8'hFF};
		tx_bytes_q = {tx_bytes_q, 8'h7A};
		queue_frame(8'h00, 8'd1, 1'b0, 0, 1'b1);
		queue_frame(LINK_TYPE, 8'd0, 1'b1, 0, 1'b0);
		queue_frame(8'hFF, 8'hFF, 1'b0, 0, 1'b0);
		queue_random_traffic(100);
		wait_drained();

		foreach (settings[i]) begin
			write_start_byte(settings[i]);
			queue_random_traffic(70);
			wait_drained();
		end

		$display("%0d bytes checked over 5 start-byte settings: %0d good and %0d bad frame ends",
			results_seen, frames_good, frames_bad);
		$display("link flag %s, %0d mismatches", link_up ? "raised" : "never raised",
			mismatch_count);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/sfrc_pkg.sv
hw/rtl/sfrc_in_stage.sv
hw/rtl/sfrc_parser.sv
hw/rtl/sfrc_out_stage.sv
hw/rtl/serial_frame_receiver_checksum.sv
sim/tb_serial_frame_receiver_checksum.sv
